### rtl/disparity_to_point_reprojection_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disparity to point reprojection block
// Shared property shorthands; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_POINT_REPROJECTION_TOP_MACROS_SVH
`define DISPARITY_TO_POINT_REPROJECTION_TOP_MACROS_SVH

// Same-cycle implication.
`define D2P_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define D2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/d2p_pkg.sv
// ----------------------------------------------------------------------------
// d2p_pkg
// Types and constants shared by the reprojection pipeline.
// ----------------------------------------------------------------------------
package d2p_pkg;

  // Divisor width: the depth divisor is 2 * D * 2^12 with D below 2^32.
  localparam int unsigned MW = 45;
  // Quotient bits produced by the divider row; larger values saturate.
  localparam int unsigned QW = 31;
  localparam int unsigned LANES = 3;

  typedef enum logic [2:0] {
    CFG_FOCAL_NORM      = 3'd0,
    CFG_BASELINE        = 3'd1,
    CFG_DISPARITY_SCALE = 3'd2,
    CFG_IMAGE_WIDTH     = 3'd3,
    CFG_IMAGE_HEIGHT    = 3'd4,
    CFG_BIG_ENDIAN      = 3'd5
  } cfg_idx_e;

  localparam logic [23:0] FOCAL_NORM_RST      = 24'd1048576;
  localparam logic [23:0] BASELINE_RST        = 24'd1090519;
  localparam logic [15:0] DISPARITY_SCALE_RST = 16'd4096;
  localparam logic [11:0] IMAGE_WIDTH_RST     = 12'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST    = 12'd480;

  // Per-pixel flags that ride along with the division.
  typedef struct packed {
    logic valid;
    logic rend;
    logic fend;
    logic negx;
    logic negy;
    logic ovx;
    logic ovy;
    logic ovz;
  } side_t;

endpackage

### rtl/disparity_to_point_reprojection_top.sv
// Throughput: one pixel per clock unless stalled; the 31-cell divider row takes a new pixel every enabled cycle.
// Stalls: the whole pipeline holds while a finished result waits at the output.
// Reset: asynchronous, active low; clears position counters, valid bits and
// the configuration registers to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_top
// Converts a raster stream of disparity pixels into saturated Q16.16 points.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection_top #(
  parameter int unsigned MAX_DIM = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel. It is always ready.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // Pixel request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_disparity_i,
  // Point result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic [31:0] point_z_o,
  output logic        point_valid_o,
  output logic        row_end_o,
  output logic        frame_end_o
);

  // DW holds an effective dimension up to MAX_DIM itself.
  localparam int unsigned DW = $clog2(MAX_DIM) + 1;
  // Remainder width covers the depth dividend 2*F*W*B + D*2^12.
  localparam int unsigned RW = DW + 50;
  localparam int unsigned NC = d2p_pkg::QW;

  logic [23:0] focal_q, baseline_q;
  logic [15:0] scale_q;
  logic [11:0] width_q, height_q;
  logic        big_endian_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q      <= d2p_pkg::FOCAL_NORM_RST;
      baseline_q   <= d2p_pkg::BASELINE_RST;
      scale_q      <= d2p_pkg::DISPARITY_SCALE_RST;
      width_q      <= d2p_pkg::IMAGE_WIDTH_RST;
      height_q     <= d2p_pkg::IMAGE_HEIGHT_RST;
      big_endian_q <= 1'b0;
    end else if (cfg_valid_i) begin
      // Indexes past the register list fall into the default arm and are dropped.
      unique case (cfg_index_i)
        d2p_pkg::CFG_FOCAL_NORM:      focal_q      <= cfg_data_i;
        d2p_pkg::CFG_BASELINE:        baseline_q   <= cfg_data_i;
        d2p_pkg::CFG_DISPARITY_SCALE: scale_q      <= cfg_data_i[15:0];
        d2p_pkg::CFG_IMAGE_WIDTH:     width_q      <= cfg_data_i[11:0];
        d2p_pkg::CFG_IMAGE_HEIGHT:    height_q     <= cfg_data_i[11:0];
        d2p_pkg::CFG_BIG_ENDIAN:      big_endian_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one and anything past MAX_DIM is clamped.
  logic [DW-1:0] w_eff, h_eff;
  assign w_eff = (width_q == 12'd0) ? DW'(1) :
                 (32'(width_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(width_q);
  assign h_eff = (height_q == 12'd0) ? DW'(1) :
                 (32'(height_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(height_q);

  // The pipeline moves as a whole unless the output holds an untaken result.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic                                       vld_s  [NC+1];
  d2p_pkg::side_t                             side_s [NC+1];
  logic [d2p_pkg::LANES-1:0][RW-1:0]          rem_s  [NC+1];
  logic [d2p_pkg::LANES-1:0][d2p_pkg::MW-1:0] den_s  [NC+1];
  logic [d2p_pkg::LANES-1:0][d2p_pkg::QW-1:0] quo_s  [NC+1];

  d2p_front #(.DW(DW), .RW(RW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .accept_i     (in_valid_i),
    .raw_i        (raw_disparity_i),
    .focal_i      (focal_q),
    .baseline_i   (baseline_q),
    .scale_i      (scale_q),
    .big_endian_i (big_endian_q),
    .w_i          (w_eff),
    .h_i          (h_eff),
    .vld_o        (vld_s[0]),
    .side_o       (side_s[0]),
    .num_o        (rem_s[0]),
    .den_o        (den_s[0])
  );
  assign quo_s[0] = '0;

  // Cell k resolves quotient bit NC-1-k, most significant first.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    d2p_div_cell #(.RW(RW), .SHIFT(NC - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_s[k]),
      .side_i (side_s[k]),
      .rem_i  (rem_s[k]),
      .den_i  (den_s[k]),
      .quo_i  (quo_s[k]),
      .vld_o  (vld_s[k+1]),
      .side_o (side_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .den_o  (den_s[k+1]),
      .quo_o  (quo_s[k+1])
    );
  end

  // Sign and saturation. Overflowed magnitudes map to the range limits.
  function automatic logic [31:0] sat_sign(input logic [d2p_pkg::QW-1:0] q,
                                           input logic ov, input logic neg);
    logic [31:0] m;
    m = {1'b0, q};
    if (ov) begin
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return neg ? 32'd0 - m : m;
  endfunction

  d2p_pkg::side_t sd;
  assign sd = side_s[NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_s[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      point_x_o     <= sd.valid ? sat_sign(quo_s[NC][0], sd.ovx, sd.negx) : 32'd0;
      point_y_o     <= sd.valid ? sat_sign(quo_s[NC][1], sd.ovy, sd.negy) : 32'd0;
      point_z_o     <= sd.valid ? sat_sign(quo_s[NC][2], sd.ovz, 1'b0) : 32'd0;
      point_valid_o <= sd.valid;
      row_end_o     <= sd.rend;
      frame_end_o   <= sd.fend;
    end
  end

endmodule

### rtl/d2p_front.sv
// ----------------------------------------------------------------------------
// d2p_front
// Position counters, byte order, products and dividend/divisor forming.
// ----------------------------------------------------------------------------
module d2p_front #(
  parameter int unsigned DW = 12,
  parameter int unsigned RW = 62
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      accept_i,
  input  logic [15:0]                               raw_i,
  input  logic [23:0]                               focal_i,
  input  logic [23:0]                               baseline_i,
  input  logic [15:0]                               scale_i,
  input  logic                                      big_endian_i,
  input  logic [DW-1:0]                             w_i,
  input  logic [DW-1:0]                             h_i,
  output logic                                      vld_o,
  output d2p_pkg::side_t                            side_o,
  output logic [d2p_pkg::LANES-1:0][RW-1:0]         num_o,
  output logic [d2p_pkg::LANES-1:0][d2p_pkg::MW-1:0] den_o
);

  localparam int unsigned CW = DW - 1;
  localparam int unsigned LANES_L = d2p_pkg::LANES;

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic          rend, fend;
  logic [DW-1:0] ax, ay;

  assign rend  = {1'b0, col_q} >= (w_i - DW'(1));
  assign fend  = rend && ({1'b0, row_q} >= (h_i - DW'(1)));
  assign ax    = {col_q, 1'b1};
  assign ay    = {row_q, 1'b1};
  assign col_d = rend ? '0 : col_q + CW'(1);
  assign row_d = fend ? '0 : (rend ? row_q + CW'(1) : row_q);

  // Stage A
  logic          a_vld_q, a_rend_q, a_fend_q, a_negx_q, a_negy_q;
  logic [15:0]   a_v_q;
  logic [DW-1:0] a_nx_q, a_ny_q, a_w_q;
  // Stage B
  logic             b_vld_q, b_rend_q, b_fend_q, b_negx_q, b_negy_q;
  logic [31:0]      b_d_q;
  logic [DW+23:0]   b_nxb_q, b_nyb_q, b_fw_q;
  // Stage C
  logic             c_vld_q, c_rend_q, c_fend_q, c_negx_q, c_negy_q;
  logic [31:0]      c_d_q;
  logic [DW+23:0]   c_nxb_q, c_nyb_q;
  logic [DW+47:0]   c_zn_q;

  logic [LANES_L-1:0][RW-1:0]          num_d;
  logic [LANES_L-1:0][d2p_pkg::MW-1:0] den_d;

  always_comb begin
    num_d[0] = RW'({c_nxb_q, 8'd0}) + RW'(c_d_q);
    num_d[1] = RW'({c_nyb_q, 8'd0}) + RW'(c_d_q);
    num_d[2] = RW'({c_zn_q, 1'b0}) + RW'({c_d_q, 12'd0});
    den_d[0] = d2p_pkg::MW'({c_d_q, 1'b0});
    den_d[1] = d2p_pkg::MW'({c_d_q, 1'b0});
    den_d[2] = {c_d_q, 13'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      vld_o   <= 1'b0;
    end else if (en_i) begin
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      a_vld_q <= accept_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      vld_o   <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_v_q    <= big_endian_i ? raw_i : {raw_i[7:0], raw_i[15:8]};
      a_rend_q <= rend;
      a_fend_q <= fend;
      a_negx_q <= ax < w_i;
      a_negy_q <= ay < h_i;
      a_nx_q   <= (ax < w_i) ? w_i - ax : ax - w_i;
      a_ny_q   <= (ay < h_i) ? h_i - ay : ay - h_i;
      a_w_q    <= w_i;

      b_d_q    <= 32'(scale_i) * 32'(a_v_q);
      b_nxb_q  <= (DW+24)'(a_nx_q) * (DW+24)'(baseline_i);
      b_nyb_q  <= (DW+24)'(a_ny_q) * (DW+24)'(baseline_i);
      b_fw_q   <= (DW+24)'(a_w_q) * (DW+24)'(focal_i);
      b_rend_q <= a_rend_q;
      b_fend_q <= a_fend_q;
      b_negx_q <= a_negx_q;
      b_negy_q <= a_negy_q;

      c_d_q    <= b_d_q;
      c_nxb_q  <= b_nxb_q;
      c_nyb_q  <= b_nyb_q;
      c_zn_q   <= (DW+48)'(b_fw_q) * (DW+48)'(baseline_i);
      c_rend_q <= b_rend_q;
      c_fend_q <= b_fend_q;
      c_negx_q <= b_negx_q;
      c_negy_q <= b_negy_q;

      // A quotient of 2^31 or more saturates; test it before the divider row.
      side_o.valid <= c_d_q != 32'd0;
      side_o.rend  <= c_rend_q;
      side_o.fend  <= c_fend_q;
      side_o.negx  <= c_negx_q;
      side_o.negy  <= c_negy_q;
      side_o.ovx   <= (num_d[0] >> d2p_pkg::QW) >= RW'(den_d[0]);
      side_o.ovy   <= (num_d[1] >> d2p_pkg::QW) >= RW'(den_d[1]);
      side_o.ovz   <= (num_d[2] >> d2p_pkg::QW) >= RW'(den_d[2]);
      num_o        <= num_d;
      den_o        <= den_d;
    end
  end

endmodule

### rtl/d2p_div_cell.sv
// ----------------------------------------------------------------------------
// d2p_div_cell
// One restoring-division step for the three coordinate lanes.
// ----------------------------------------------------------------------------
module d2p_div_cell #(
  parameter int unsigned RW    = 62,
  parameter int unsigned SHIFT = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       vld_i,
  input  d2p_pkg::side_t                             side_i,
  input  logic [d2p_pkg::LANES-1:0][RW-1:0]          rem_i,
  input  logic [d2p_pkg::LANES-1:0][d2p_pkg::MW-1:0] den_i,
  input  logic [d2p_pkg::LANES-1:0][d2p_pkg::QW-1:0] quo_i,
  output logic                                       vld_o,
  output d2p_pkg::side_t                             side_o,
  output logic [d2p_pkg::LANES-1:0][RW-1:0]          rem_o,
  output logic [d2p_pkg::LANES-1:0][d2p_pkg::MW-1:0] den_o,
  output logic [d2p_pkg::LANES-1:0][d2p_pkg::QW-1:0] quo_o
);

  logic [d2p_pkg::LANES-1:0][RW-1:0]          rem_d;
  logic [d2p_pkg::LANES-1:0][d2p_pkg::QW-1:0] quo_d;

  always_comb begin
    for (int l = 0; l < d2p_pkg::LANES; l++) begin
      quo_d[l] = quo_i[l];
      // The shifted divisor has zero low bits, so compare the high part only.
      if ((rem_i[l] >> SHIFT) >= RW'(den_i[l])) begin
        rem_d[l]        = rem_i[l] - (RW'(den_i[l]) << SHIFT);
        quo_d[l][SHIFT] = 1'b1;
      end else begin
        rem_d[l] = rem_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rem_o  <= rem_d;
      den_o  <= den_i;
      quo_o  <= quo_d;
    end
  end

endmodule

### rtl/d2p_checker.sv
// ----------------------------------------------------------------------------
// d2p_checker
// Port-level checks on the point result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "disparity_to_point_reprojection_top_macros.svh"

module d2p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] point_x_o,
  input logic [31:0] point_y_o,
  input logic [31:0] point_z_o,
  input logic        point_valid_o,
  input logic        row_end_o,
  input logic        frame_end_o
);

  // A stalled result holds its x and z coordinates.
  `D2P_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, $stable(point_x_o) && $stable(point_z_o))
  // A point without disparity carries zero coordinates.
  `D2P_ASSERT_IMPLY(a_zero, out_valid_o && !point_valid_o, point_x_o == 32'd0 && point_y_o == 32'd0 && point_z_o == 32'd0)
  // The last pixel of a frame is also the last of its row.
  `D2P_ASSERT_IMPLY(a_fend, out_valid_o && frame_end_o, row_end_o)
  // Depth is never negative.
  `D2P_ASSERT_IMPLY(a_zpos, out_valid_o, !point_z_o[31])

endmodule

bind disparity_to_point_reprojection_top d2p_checker u_d2p_checker (.*);

### tb/sv/tb_disparity_to_point_reprojection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the disparity to point reprojection block
// Streams raster disparity pixels through the block under several register
// settings, predicts every point in a scoreboard and checks each result.
// ----------------------------------------------------------------------------

// Expected point for one accepted disparity request.
typedef struct packed {
  logic [31:0] x;
  logic [31:0] y;
  logic [31:0] z;
  logic        pvalid;
  logic        rend;
  logic        fend;
} point_t;

class point_scoreboard;
  point_t      pending_q[$];
  int unsigned errors;
  // Register copies and raster position of the next pixel.
  logic [23:0] focal;
  logic [23:0] base;
  logic [15:0] dscale;
  logic [11:0] width;
  logic [11:0] height;
  logic        big_end;
  int unsigned col;
  int unsigned row;
  int unsigned max_dim;

  function new(int unsigned max_dim_p);
    max_dim = max_dim_p;
    focal = d2p_pkg::FOCAL_NORM_RST;
    base = d2p_pkg::BASELINE_RST;
    dscale = d2p_pkg::DISPARITY_SCALE_RST;
    width = d2p_pkg::IMAGE_WIDTH_RST;
    height = d2p_pkg::IMAGE_HEIGHT_RST;
    big_end = 1'b0;
    col = 0;
    row = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [23:0] data);
    case (idx)
      d2p_pkg::CFG_FOCAL_NORM: focal = data;
      d2p_pkg::CFG_BASELINE: base = data;
      d2p_pkg::CFG_DISPARITY_SCALE: dscale = data[15:0];
      d2p_pkg::CFG_IMAGE_WIDTH: width = data[11:0];
      d2p_pkg::CFG_IMAGE_HEIGHT: height = data[11:0];
      d2p_pkg::CFG_BIG_ENDIAN: big_end = data[0];
      default: ;
    endcase
  endfunction

  function int unsigned clamp_dim(logic [11:0] v);
    if (v == 0) return 1;
    if (v > max_dim) return max_dim;
    return v;
  endfunction

  // Round to nearest on the magnitude, ties away from zero.
  function logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function logic [31:0] saturate(logic [63:0] mag, bit neg);
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function logic [31:0] offset_coord(int unsigned a, int unsigned b, logic [63:0] d);
    bit          neg;
    logic [63:0] n;
    neg = a < b;
    n = neg ? 64'(b - a) : 64'(a - b);
    return saturate(round_div((n * base) << 7, d), neg);
  endfunction

  // Predict the point for one accepted pixel and advance the raster position.
  function void note_pixel(logic [15:0] raw);
    int unsigned w;
    int unsigned h;
    logic [15:0] v;
    logic [63:0] d;
    point_t      p;
    w = clamp_dim(width);
    h = clamp_dim(height);
    v = big_end ? raw : {raw[7:0], raw[15:8]};
    d = 64'(dscale) * 64'(v);
    p.rend = col >= w - 1;
    p.fend = p.rend && (row >= h - 1);
    if (d != 0) begin
      p.x = offset_coord(2 * col + 1, w, d);
      p.y = offset_coord(2 * row + 1, h, d);
      p.z = saturate(round_div(64'(focal) * 64'(w) * 64'(base), d << 12), 1'b0);
      p.pvalid = 1'b1;
    end else begin
      p.x = '0;
      p.y = '0;
      p.z = '0;
      p.pvalid = 1'b0;
    end
    pending_q.push_back(p);
    if (p.rend) begin
      col = 0;
      row = p.fend ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function void check_point(point_t got);
    point_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected point result x=%h y=%h z=%h", $time, got.x, got.y, got.z);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.x !== e.x) begin
      $display("%0t: point_x expected %h actual %h", $time, e.x, got.x);
      errors++;
    end
    if (got.y !== e.y) begin
      $display("%0t: point_y expected %h actual %h", $time, e.y, got.y);
      errors++;
    end
    if (got.z !== e.z) begin
      $display("%0t: point_z expected %h actual %h", $time, e.z, got.z);
      errors++;
    end
    if (got.pvalid !== e.pvalid) begin
      $display("%0t: point_valid expected %b actual %b", $time, e.pvalid, got.pvalid);
      errors++;
    end
    if (got.rend !== e.rend) begin
      $display("%0t: row_end expected %b actual %b", $time, e.rend, got.rend);
      errors++;
    end
    if (got.fend !== e.fend) begin
      $display("%0t: frame_end expected %b actual %b", $time, e.fend, got.fend);
      errors++;
    end
  endfunction
endclass

module tb_disparity_to_point_reprojection_top;

  localparam int unsigned MAX_DIM = 2048;
  // Index past the register list; the block must ignore such writes.
  localparam logic [2:0] CFG_UNUSED_A = 3'd6;
  localparam logic [2:0] CFG_UNUSED_B = 3'd7;
  // Drain wait after the last result, well above the pipeline latency.
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] raw_disparity_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] point_x_o;
  logic [31:0] point_y_o;
  logic [31:0] point_z_o;
  logic        point_valid_o;
  logic        row_end_o;
  logic        frame_end_o;

  point_scoreboard sb;
  int unsigned     cycles;
  int unsigned     results_seen;
  // When set, neither side idles, so the pipeline runs at full rate.
  bit              no_idle;

  disparity_to_point_reprojection_top #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_disparity_i(raw_disparity_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .point_z_o      (point_z_o),
    .point_valid_o  (point_valid_o),
    .row_end_o      (row_end_o),
    .frame_end_o    (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The run is bounded by a cycle counter so that a hung pipeline still ends.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor: a point is taken when valid is high and we do not stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_point({point_x_o, point_y_o, point_z_o, point_valid_o, row_end_o,
                      frame_end_o});
      results_seen <= results_seen + 1;
    end
  end

  // Receiver stall pattern. Once, after a hundred results, it holds off for a
  // long stretch while the sender keeps offering requests, so the pipeline
  // fills up and has to stall its input.
  initial begin : receiver
    int unsigned gap;
    bit          held;
    held = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 100) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap - 1) @(negedge clk_i);
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Offer one disparity request and hold it until the block takes it. Valid
  // stays high into the next request when there is no gap.
  task automatic send_pixel(logic [15:0] raw);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    raw_disparity_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(raw);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers may only change once the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random disparity words: some zero, some with only one byte set, the
  // rest spread over the whole range.
  function automatic logic [15:0] pick_raw();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return {8'h00, 8'($urandom())};
    if (r < 30) return {8'($urandom()), 8'h00};
    return 16'($urandom());
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_pixel(pick_raw());
  endtask

  // Random register setting; small images so row and frame ends come often.
  task automatic random_setting();
    int unsigned r;
    r = $urandom_range(0, 3);
    write_reg(d2p_pkg::CFG_FOCAL_NORM, 24'($urandom()));
    write_reg(d2p_pkg::CFG_BASELINE, 24'($urandom()));
    case (r)
      0: write_reg(d2p_pkg::CFG_DISPARITY_SCALE, 24'($urandom_range(1, 15)));
      1: write_reg(d2p_pkg::CFG_DISPARITY_SCALE, 24'hFFFF);
      default: write_reg(d2p_pkg::CFG_DISPARITY_SCALE, 24'($urandom_range(0, 65535)));
    endcase
    write_reg(d2p_pkg::CFG_IMAGE_WIDTH, 24'($urandom_range(1, 12)));
    write_reg(d2p_pkg::CFG_IMAGE_HEIGHT, 24'($urandom_range(1, 6)));
    write_reg(d2p_pkg::CFG_BIG_ENDIAN, 24'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    logic [15:0] corner_raw [8];
    sb = new(MAX_DIM);
    no_idle = 0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    raw_disparity_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    corner_raw = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'h8000, 16'h0080,
                   16'h00FF, 16'hFF00};

    // Directed part at reset defaults: extreme words, zero disparity, and
    // the first pixels of a wide row.
    foreach (corner_raw[i]) send_pixel(corner_raw[i]);

    // Tiny image with big-endian words: exercises row and frame ends.
    wait_idle();
    write_reg(d2p_pkg::CFG_IMAGE_WIDTH, 24'd3);
    write_reg(d2p_pkg::CFG_IMAGE_HEIGHT, 24'd2);
    write_reg(d2p_pkg::CFG_BIG_ENDIAN, 24'd1);
    foreach (corner_raw[i]) send_pixel(corner_raw[i]);

    // Out-of-range sizes: zero width acts as one, an oversized height is
    // clamped. The shrink mid-frame also makes the counters wrap.
    wait_idle();
    write_reg(d2p_pkg::CFG_IMAGE_WIDTH, 24'd0);
    write_reg(d2p_pkg::CFG_IMAGE_HEIGHT, 24'hFFF);
    write_reg(CFG_UNUSED_A, 24'hFFFFFF);
    write_reg(CFG_UNUSED_B, 24'h000001);
    send_pixel(16'h0100);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);

    // Largest products with the smallest scale: disparity word 1 saturates every coordinate.
    wait_idle();
    write_reg(d2p_pkg::CFG_FOCAL_NORM, 24'hFFFFFF);
    write_reg(d2p_pkg::CFG_BASELINE, 24'hFFFFFF);
    write_reg(d2p_pkg::CFG_DISPARITY_SCALE, 24'd1);
    write_reg(d2p_pkg::CFG_IMAGE_WIDTH, 24'd2048);
    write_reg(d2p_pkg::CFG_IMAGE_HEIGHT, 24'd2);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);

    // Zero registers: zero scale means every point is flagged invalid.
    wait_idle();
    write_reg(d2p_pkg::CFG_FOCAL_NORM, 24'd0);
    write_reg(d2p_pkg::CFG_BASELINE, 24'd0);
    write_reg(d2p_pkg::CFG_DISPARITY_SCALE, 24'd0);
    write_reg(d2p_pkg::CFG_IMAGE_WIDTH, 24'd1);
    write_reg(d2p_pkg::CFG_IMAGE_HEIGHT, 24'd1);
    send_pixel(16'hFFFF);
    send_pixel(16'h1234);

    // Random part: several register settings, one run at full rate.
    for (int ph = 0; ph < 11; ph++) begin
      wait_idle();
      random_setting();
      no_idle = (ph == 3);
      send_random(80);
    end
    no_idle = 0;

    // Reset defaults restored, with a moderate image for a few full rows.
    wait_idle();
    write_reg(d2p_pkg::CFG_FOCAL_NORM, d2p_pkg::FOCAL_NORM_RST);
    write_reg(d2p_pkg::CFG_BASELINE, d2p_pkg::BASELINE_RST);
    write_reg(d2p_pkg::CFG_DISPARITY_SCALE, 24'(d2p_pkg::DISPARITY_SCALE_RST));
    write_reg(d2p_pkg::CFG_IMAGE_WIDTH, 24'd16);
    write_reg(d2p_pkg::CFG_IMAGE_HEIGHT, 24'd3);
    write_reg(d2p_pkg::CFG_BIG_ENDIAN, 24'd0);
    send_random(40);

    wait_idle();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
